// ===== sv/mbrtu_pkg.sv =====
// mbrtu_pkg: item types and fixed codes of the modbus rtu master frame engine
// no dependencies; used by modbus_rtu_master_frame_engine
`default_nettype none

package mbrtu_pkg;

  // input transaction codes
  localparam logic [1:0] FUNC_REQ  = 2'd0;
  localparam logic [1:0] FUNC_RX   = 2'd1;
  localparam logic [1:0] FUNC_END  = 2'd2;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  // result kinds
  localparam logic [1:0] KIND_TX     = 2'd0;
  localparam logic [1:0] KIND_REG    = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // modbus function code that reads holding registers
  localparam logic [7:0] FC_READ_REGS = 8'h03;

  // crc-16, reflected
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // status bits
  localparam int unsigned STAT_CRC_BIT   = 6;
  localparam logic [7:0]  STAT_CRC_MASK  = 8'h40;
  localparam logic [7:0]  STAT_SHORT_MASK = 8'h80;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  slave_addr;
    logic [7:0]  function_code;
    logic [15:0] reg_addr;
    logic [15:0] data_word;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [7:0]  tx_byte;
    logic [3:0]  reg_index;
    logic [15:0] reg_value;
    logic [7:0]  status;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== sv/mbrtu_ram.sv =====
// mbrtu_ram: generic single write port ram with one registered read port
// no dependencies
`default_nettype none

module mbrtu_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/modbus_rtu_master_frame_engine.sv =====
// modbus_rtu_master_frame_engine: framing core of a modbus rtu master
// depends on mbrtu_pkg and mbrtu_ram
//
// Input transactions (in_valid_i/in_ready_o, in_item_i) carry one of three
// commands: send a request, one received response byte, or end of response.
// A request yields eight transmit bytes (address, function, register, word,
// crc low, crc high). Response bytes yield nothing. An end yields a status
// result, and for a good read response first one result per register.
// Results leave on out_valid_o/out_ready_o through one output register.
// The block takes one transaction at a time; in_ready_o is high only while
// it is idle. A single bit-serial crc unit (one polynomial step a cycle)
// computes the request crc over the six header bytes and folds each
// response data byte into the running crc; register values are read back
// from the ram one at a time. A stalled receiver holds the output
// register and the sequencer waits. Reset clears the request to all zeros
// and the crc accumulator to 0xFFFF; the register ram needs no clearing.
`default_nettype none

module modbus_rtu_master_frame_engine #(
  parameter int unsigned MAX_REGS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire mbrtu_pkg::in_item_t  in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output mbrtu_pkg::out_item_t      out_item_o
);

  localparam int unsigned MaxLen = (2 * MAX_REGS + 5 > 8) ? 2 * MAX_REGS + 5 : 8;
  localparam int unsigned CW     = $clog2(MaxLen + 1);
  localparam int unsigned AW     = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam int unsigned KW     = $clog2(MAX_REGS + 1);

  // sequencer states
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_TX_XOR   = 4'd1;
  localparam logic [3:0] S_TX_SHIFT = 4'd2;
  localparam logic [3:0] S_TX_EMIT  = 4'd3;
  localparam logic [3:0] S_RX_BYTE  = 4'd4;
  localparam logic [3:0] S_RX_SHIFT = 4'd5;
  localparam logic [3:0] S_RX_NEXT  = 4'd6;
  localparam logic [3:0] S_END_READ = 4'd7;
  localparam logic [3:0] S_RD_REQ   = 4'd8;
  localparam logic [3:0] S_RD_WAIT  = 4'd9;
  localparam logic [3:0] S_STAT     = 4'd10;

  logic [3:0]  state_q, state_d;
  // request
  logic [7:0]  req_addr_q, req_addr_d;
  logic [7:0]  req_func_q, req_func_d;
  logic [15:0] req_reg_q, req_reg_d;
  logic [15:0] req_word_q, req_word_d;
  // committed receive context
  logic [CW-1:0] rx_cnt_q, rx_cnt_d;
  logic [15:0]   run_crc_q, run_crc_d;
  logic [15:0]   frz_crc_q, frz_crc_d;
  logic [7:0]    err_q, err_d;
  logic [7:0]    held_q, held_d;
  // working copy of the receive context
  logic [CW-1:0] cnt_w_q, cnt_w_d;
  logic [15:0]   crc_w_q, crc_w_d;
  logic [15:0]   frz_w_q, frz_w_d;
  logic [7:0]    err_w_q, err_w_d;
  // sequencer scratch
  logic [7:0]    b_q, b_d;
  logic          end_mode_q, end_mode_d;
  logic          short_q, short_d;
  logic [2:0]    tb_q, tb_d;
  logic [2:0]    bit_q, bit_d;
  logic [KW-1:0] k_q, k_d;
  logic [7:0]    stat_q, stat_d;
  // output register
  logic                 out_valid_q, out_valid_d;
  mbrtu_pkg::out_item_t out_item_q, out_item_d;

  // ram ports
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic          is_read;
  logic [CW-1:0] exp_len;
  logic [CW:0]   cnt_p2;
  logic [CW:0]   len_ext;
  logic [CW-1:0] q_idx;
  logic          slot_free;
  logic [15:0]   word_clamped;

  // one polynomial step of the shared crc unit
  function automatic logic [15:0] crc_shift(input logic [15:0] c);
    return c[0] ? ((c >> 1) ^ mbrtu_pkg::CRC_POLY) : (c >> 1);
  endfunction

  // byte of the request frame at a position
  function automatic logic [7:0] frame_byte(input logic [2:0] idx, input logic [7:0] a,
                                            input logic [7:0] f, input logic [15:0] r,
                                            input logic [15:0] w, input logic [15:0] c);
    logic [7:0] res;
    case (idx)
      3'd0:    res = a;
      3'd1:    res = f;
      3'd2:    res = r[15:8];
      3'd3:    res = r[7:0];
      3'd4:    res = w[15:8];
      3'd5:    res = w[7:0];
      3'd6:    res = c[7:0];
      default: res = c[15:8];
    endcase
    return res;
  endfunction

  assign is_read   = (req_func_q == mbrtu_pkg::FC_READ_REGS);
  assign exp_len   = is_read ? CW'({req_word_q, 1'b0} + 17'd5) : CW'(8);
  assign cnt_p2    = {1'b0, cnt_w_q} + (CW+1)'(2);
  assign len_ext   = {1'b0, exp_len};
  assign q_idx     = cnt_w_q - CW'(3);
  assign slot_free = !out_valid_q || out_ready_i;

  assign word_clamped = ((in_item_i.function_code == mbrtu_pkg::FC_READ_REGS) &&
                         (in_item_i.data_word > 16'(MAX_REGS))) ?
                        16'(MAX_REGS) : in_item_i.data_word;

  assign ram_wdata = {held_q, b_q};
  assign ram_waddr = AW'(q_idx >> 1);
  assign ram_raddr = AW'(k_q);

  // sequencer
  always_comb begin
    state_d     = state_q;
    req_addr_d  = req_addr_q;
    req_func_d  = req_func_q;
    req_reg_d   = req_reg_q;
    req_word_d  = req_word_q;
    rx_cnt_d    = rx_cnt_q;
    run_crc_d   = run_crc_q;
    frz_crc_d   = frz_crc_q;
    err_d       = err_q;
    held_d      = held_q;
    cnt_w_d     = cnt_w_q;
    crc_w_d     = crc_w_q;
    frz_w_d     = frz_w_q;
    err_w_d     = err_w_q;
    b_d         = b_q;
    end_mode_d  = end_mode_q;
    short_d     = short_q;
    tb_d        = tb_q;
    bit_d       = bit_q;
    k_d         = k_q;
    stat_d      = stat_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_item_d  = out_item_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_item_i.func)
            mbrtu_pkg::FUNC_REQ: begin
              req_addr_d = in_item_i.slave_addr;
              req_func_d = in_item_i.function_code;
              req_reg_d  = in_item_i.reg_addr;
              req_word_d = word_clamped;
              rx_cnt_d   = '0;
              run_crc_d  = mbrtu_pkg::CRC_INIT;
              frz_crc_d  = '0;
              err_d      = '0;
              held_d     = '0;
              crc_w_d    = mbrtu_pkg::CRC_INIT;
              tb_d       = '0;
              state_d    = S_TX_XOR;
            end
            mbrtu_pkg::FUNC_RX: begin
              cnt_w_d    = rx_cnt_q;
              crc_w_d    = run_crc_q;
              frz_w_d    = frz_crc_q;
              err_w_d    = err_q;
              b_d        = in_item_i.rx_byte;
              end_mode_d = 1'b0;
              state_d    = S_RX_BYTE;
            end
            mbrtu_pkg::FUNC_END: begin
              cnt_w_d    = rx_cnt_q;
              crc_w_d    = run_crc_q;
              frz_w_d    = frz_crc_q;
              err_w_d    = err_q;
              end_mode_d = 1'b1;
              short_d    = (rx_cnt_q < exp_len);
              state_d    = is_read ? S_END_READ : S_RX_NEXT;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // crc over the six header bytes of the request
      S_TX_XOR: begin
        crc_w_d = crc_w_q ^ {8'h00, frame_byte(tb_q, req_addr_q, req_func_q, req_reg_q,
                                               req_word_q, crc_w_q)};
        bit_d   = '0;
        state_d = S_TX_SHIFT;
      end
      S_TX_SHIFT: begin
        crc_w_d = crc_shift(crc_w_q);
        bit_d   = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          if (tb_q == 3'd5) begin
            tb_d    = '0;
            state_d = S_TX_EMIT;
          end else begin
            tb_d    = tb_q + 3'd1;
            state_d = S_TX_XOR;
          end
        end
      end

      // hand out the eight frame bytes
      S_TX_EMIT: begin
        if (slot_free) begin
          out_valid_d         = 1'b1;
          out_item_d          = '0;
          out_item_d.out_kind = mbrtu_pkg::KIND_TX;
          out_item_d.tx_byte  = frame_byte(tb_q, req_addr_q, req_func_q, req_reg_q,
                                           req_word_q, crc_w_q);
          out_item_d.last     = (tb_q == 3'd7);
          tb_d                = tb_q + 3'd1;
          if (tb_q == 3'd7) begin
            state_d = S_IDLE;
          end
        end
      end

      // one response byte against the working context
      S_RX_BYTE: begin
        if (cnt_w_q >= exp_len) begin
          state_d = S_RX_NEXT;
        end else if (cnt_p2 < len_ext) begin
          crc_w_d = crc_w_q ^ {8'h00, b_q};
          bit_d   = '0;
          if (!is_read) begin
            if (b_q != frame_byte(cnt_w_q[2:0], req_addr_q, req_func_q, req_reg_q,
                                  req_word_q, crc_w_q)) begin
              err_w_d[cnt_w_q[2:0]] = 1'b1;
            end
          end else if (cnt_w_q >= CW'(3)) begin
            if (!q_idx[0]) begin
              held_d = b_q;
            end else begin
              ram_we = !end_mode_q;
            end
          end
          state_d = S_RX_SHIFT;
        end else if (cnt_p2 == len_ext) begin
          frz_w_d = crc_w_q;
          if (b_q != crc_w_q[7:0]) begin
            err_w_d[mbrtu_pkg::STAT_CRC_BIT] = 1'b1;
          end
          cnt_w_d = cnt_w_q + CW'(1);
          state_d = S_RX_NEXT;
        end else begin
          if (b_q != frz_w_q[15:8]) begin
            err_w_d[mbrtu_pkg::STAT_CRC_BIT] = 1'b1;
          end
          cnt_w_d = cnt_w_q + CW'(1);
          state_d = S_RX_NEXT;
        end
      end
      S_RX_SHIFT: begin
        crc_w_d = crc_shift(crc_w_q);
        bit_d   = bit_q + 3'd1;
        if (bit_q == 3'd7) begin
          cnt_w_d = cnt_w_q + CW'(1);
          state_d = S_RX_NEXT;
        end
      end

      // commit a byte, or pad a short echo with zero bytes
      S_RX_NEXT: begin
        if (!end_mode_q) begin
          rx_cnt_d  = cnt_w_q;
          run_crc_d = crc_w_q;
          frz_crc_d = frz_w_q;
          err_d     = err_w_q;
          state_d   = S_IDLE;
        end else if (cnt_w_q < exp_len) begin
          b_d     = '0;
          state_d = S_RX_BYTE;
        end else begin
          stat_d  = err_w_q | (short_q ? mbrtu_pkg::STAT_SHORT_MASK : 8'h00);
          state_d = S_STAT;
        end
      end

      // end of a read response
      S_END_READ: begin
        if (short_q) begin
          stat_d  = mbrtu_pkg::STAT_SHORT_MASK;
          state_d = S_STAT;
        end else if (err_q[mbrtu_pkg::STAT_CRC_BIT]) begin
          stat_d  = mbrtu_pkg::STAT_CRC_MASK;
          state_d = S_STAT;
        end else begin
          k_d     = '0;
          state_d = S_RD_REQ;
        end
      end
      S_RD_REQ: begin
        if (16'(k_q) < req_word_q) begin
          ram_re  = 1'b1;
          state_d = S_RD_WAIT;
        end else begin
          stat_d  = 8'h00;
          state_d = S_STAT;
        end
      end
      S_RD_WAIT: begin
        if (slot_free) begin
          out_valid_d          = 1'b1;
          out_item_d           = '0;
          out_item_d.out_kind  = mbrtu_pkg::KIND_REG;
          out_item_d.reg_index = 4'(k_q);
          out_item_d.reg_value = ram_rdata;
          k_d                  = k_q + KW'(1);
          state_d              = S_RD_REQ;
        end
      end

      // completion status
      S_STAT: begin
        if (slot_free) begin
          out_valid_d         = 1'b1;
          out_item_d          = '0;
          out_item_d.out_kind = mbrtu_pkg::KIND_STATUS;
          out_item_d.status   = stat_q;
          out_item_d.last     = 1'b1;
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_addr_q  <= '0;
      req_func_q  <= '0;
      req_reg_q   <= '0;
      req_word_q  <= '0;
      rx_cnt_q    <= '0;
      run_crc_q   <= mbrtu_pkg::CRC_INIT;
      frz_crc_q   <= '0;
      err_q       <= '0;
      held_q      <= '0;
      cnt_w_q     <= '0;
      crc_w_q     <= '0;
      frz_w_q     <= '0;
      err_w_q     <= '0;
      b_q         <= '0;
      end_mode_q  <= 1'b0;
      short_q     <= 1'b0;
      tb_q        <= '0;
      bit_q       <= '0;
      k_q         <= '0;
      stat_q      <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
    end else begin
      state_q     <= state_d;
      req_addr_q  <= req_addr_d;
      req_func_q  <= req_func_d;
      req_reg_q   <= req_reg_d;
      req_word_q  <= req_word_d;
      rx_cnt_q    <= rx_cnt_d;
      run_crc_q   <= run_crc_d;
      frz_crc_q   <= frz_crc_d;
      err_q       <= err_d;
      held_q      <= held_d;
      cnt_w_q     <= cnt_w_d;
      crc_w_q     <= crc_w_d;
      frz_w_q     <= frz_w_d;
      err_w_q     <= err_w_d;
      b_q         <= b_d;
      end_mode_q  <= end_mode_d;
      short_q     <= short_d;
      tb_q        <= tb_d;
      bit_q       <= bit_d;
      k_q         <= k_d;
      stat_q      <= stat_d;
      out_valid_q <= out_valid_d;
      out_item_q  <= out_item_d;
    end
  end

  // holding register store
  mbrtu_ram #(
    .WIDTH (16),
    .DEPTH (MAX_REGS),
    .AW    (AW)
  ) u_reg_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a taken command with a known code leaves idle
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_item_i.func != mbrtu_pkg::FUNC_NONE)) |=> !in_ready_o)
    else $error("sequencer stayed idle after a command");

  // after the eighth crc step of a received data byte the sequencer moves to S_RX_NEXT
  a_rx_shift_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RX_SHIFT && bit_q == 3'd7) |=> (state_q == S_RX_NEXT))
    else $error("crc step count broken");

  // the working byte count never runs past the expected frame length
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RX_NEXT) |-> (cnt_w_q <= exp_len))
    else $error("receive count beyond frame length");

  // register values are only read out for a read response
  a_read_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD_REQ) |-> is_read)
    else $error("register readout outside a read");

endmodule

`default_nettype wire
